// File: src/hdrh_pkg.sv
// Shared constants, types and helpers for the HDR latency histogram.
package hdrh_pkg;

  localparam int SUB_HALF_MAG_DEF = 7;
  localparam int BUCKETS_DEF      = 15;

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Register byte addresses on the register port (64-bit data).
  localparam logic [3:0] ADDR_UNIT = 4'h0;
  localparam logic [3:0] ADDR_HT   = 4'h8;

  localparam logic [63:0] HT_RESET = 64'd4194303;

  // Request as it travels from the front end to the engine.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] value;
    logic [31:0] count;
    logic [13:0] pct;
  } req_t;

  // Statistics carried with each result item.
  typedef struct packed {
    logic [63:0] total;
    logic [63:0] clamped;
    logic [63:0] min_v;
    logic [63:0] max_v;
  } stats_t;

  // Count of leading zeros over a 64-bit word.
  function automatic logic [6:0] clz64(input logic [63:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i] && !found) begin
        n = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [63:0] shl64(input logic [63:0] v, input logic [6:0] s);
    return (s >= 7'd64) ? 64'd0 : (v << s[5:0]);
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// File: src/hdr_latency_histogram.sv
// Top level of the HDR latency histogram: stream ports, register port, engine.
//
// Input items carry a request: record a value, query a percentile or clear.
// Every request produces exactly one result item with the query value and
// the running statistics (total, clamped, min, max).
// Registers: unit_magnitude at byte 0, highest_trackable at byte 8 (64-bit
// data). Write them only while the block is idle.
// Steps from input accept to the result, run by the control sequencer over
// a counter store with one write port and one registered read port:
//   record: read, then write back.
//   clear:  one counter zeroed per cycle, over all DEPTH counters.
//   query:  the multiply, the divide by 10000 in five 16-bit digits, the
//           handoff, then a walk over the counters until the running sum
//           reaches the target, then the value and the result; a walk that
//           runs out answers 0. An empty histogram or an undefined request
//           goes straight to the result.
// One item is in work at a time; in_tready is low until the result is taken.
// After reset the block sweeps all DEPTH counters of the store to zero (2048 at the
// default parameters) and accepts no item meanwhile; registers are taken.
// When the receiver stalls, the result holds in place and no new item is
// accepted.
module hdr_latency_histogram #(
  parameter int SUB_HALF_MAG = hdrh_pkg::SUB_HALF_MAG_DEF,
  parameter int BUCKETS      = hdrh_pkg::BUCKETS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_value[63:0], sample_count[95:64], percentile_hundredths[109:96], zero fill
  input  logic [111:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // query_value, total_samples, clamped_samples, min_seen, max_seen, 64 bits each
  output logic [319:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [5:0]  unit_r;
  logic [63:0] ht_r;
  hdrh_pkg::req_t   req;
  hdrh_pkg::stats_t st;
  logic [63:0] qv;

  // Register port.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= '0;
      ht_r <= hdrh_pkg::HT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        hdrh_pkg::ADDR_UNIT: unit_r <= cfg_pwdata[5:0];
        hdrh_pkg::ADDR_HT:   ht_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      hdrh_pkg::ADDR_UNIT: cfg_prdata = {58'd0, unit_r};
      hdrh_pkg::ADDR_HT:   cfg_prdata = ht_r;
      default:             cfg_prdata = '0;
    endcase
  end

  assign req.req_type = in_tuser;
  assign req.value = in_tdata[63:0];
  assign req.count = in_tdata[95:64];
  assign req.pct = in_tdata[109:96];

  hdrh_engine #(.SUB_HALF_MAG(SUB_HALF_MAG), .BUCKETS(BUCKETS)) u_eng (
    .clk(clk), .rst_n(rst_n), .unit_mag(unit_r), .highest(ht_r),
    .req_valid(in_tvalid), .req_ready(in_tready), .req(req),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_query(qv), .res_stats(st)
  );

  assign out_tdata = {st.max_v, st.min_v, st.clamped, st.total, qv};

endmodule

// File: src/hdrh_target.sv
// Percentile target: floor((p * total + 5000) / 10000) by 16-bit digits and a reciprocal.
module hdrh_target (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [13:0] pct,
  input  logic [63:0] total,
  output logic        done,
  output logic [63:0] target
);
  localparam logic [13:0] DIVISOR = 14'd10000;
  // Reciprocal of 10000 scaled by 2^44; exact for every 30-bit dividend.
  localparam logic [30:0] RECIP  = 31'd1759218605;
  localparam int          RSHIFT = 44;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_DIVQ   = 3'd3;
  localparam logic [2:0] S_DIVR   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [79:0] prod_r, prod_nxt;
  logic [79:0] quo_r, quo_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [15:0] qd_r, qd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [13:0] pc;
  logic [31:0] mul_a;
  logic [45:0] part;
  logic [29:0] dvd, rem_full;
  logic [60:0] qprod;
  logic [15:0] qdig;

  assign pc = (pct > DIVISOR) ? DIVISOR : pct;

  // One 32 x 14 multiplier, used for the low and then the high half of the total.
  assign mul_a = (st_r == S_MUL_HI) ? total[63:32] : total[31:0];
  assign part = 46'(mul_a) * 46'(pc);

  // Digit step: remainder and the next 16 bits form a 30-bit dividend.
  assign dvd = {rem_r, prod_r[79:64]};
  assign qprod = 61'(dvd) * 61'(RECIP);
  assign qdig = qprod[RSHIFT +: 16];
  assign rem_full = dvd - 30'(qd_r) * 30'(DIVISOR);

  // Multiply the low then the high half, then five digits, each a quotient step and a remainder step.
  always_comb begin
    st_nxt = st_r;
    prod_nxt = prod_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    qd_nxt = qd_r;
    cnt_nxt = cnt_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        prod_nxt = {34'd0, part} + 80'd5000;
        rem_nxt = '0;
        quo_nxt = '0;
        st_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        prod_nxt = prod_r + {2'd0, part, 32'd0};
        cnt_nxt = 3'd5;
        st_nxt = S_DIVQ;
      end
      S_DIVQ: begin
        qd_nxt = qdig;
        quo_nxt = {quo_r[63:0], qdig};
        st_nxt = S_DIVR;
      end
      S_DIVR: begin
        rem_nxt = rem_full[13:0];
        prod_nxt = {prod_r[63:0], 16'd0};
        cnt_nxt = cnt_r - 3'd1;
        st_nxt = (cnt_r == 3'd1) ? S_DONE : S_DIVQ;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    qd_r <= qd_nxt;
  end

  assign done = (st_r == S_DONE);
  assign target = (quo_r[63:0] == 64'd0) ? 64'd1 : quo_r[63:0];

endmodule

// File: src/hdrh_engine.sv
// Counter store with record, percentile walk and clearing pass.
module hdrh_engine #(
  parameter int SUB_HALF_MAG = hdrh_pkg::SUB_HALF_MAG_DEF,
  parameter int BUCKETS      = hdrh_pkg::BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [5:0]        unit_mag,
  input  logic [63:0]       highest,
  input  logic              req_valid,
  output logic              req_ready,
  input  hdrh_pkg::req_t    req,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [63:0]       res_query,
  output hdrh_pkg::stats_t  res_stats
);
  localparam int DEPTH = (BUCKETS + 1) << SUB_HALF_MAG;
  localparam int AW    = $clog2(DEPTH);
  localparam int HALF  = 1 << SUB_HALF_MAG;
  localparam logic [5:0] ULIM = 6'(63 - SUB_HALF_MAG);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_TGT  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_EQV  = 3'd6;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [2:0]  st_r, st_nxt;
  logic [AW:0] addr_r, addr_nxt;
  logic        idx_ok_r, idx_ok_nxt;
  logic        clr_res_r, clr_res_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [13:0] pct_r, pct_nxt;
  logic [63:0] tgt_r, tgt_nxt;
  logic [63:0] run_r, run_nxt;
  logic [63:0] qv_r, qv_nxt;
  logic [63:0] tot_r, tot_nxt, clp_r, clp_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic        tgt_start, tgt_done;
  logic [63:0] tgt_val;

  // Bin index of a record value.
  logic [5:0]  eu;
  logic [63:0] cv, bmask;
  logic [6:0]  bucket, shamt;
  logic [63:0] sub, idx_full;

  assign eu = (unit_mag > ULIM) ? ULIM : unit_mag;
  assign cv = (req.value > highest) ? highest : req.value;
  assign bmask = hdrh_pkg::shl64(64'((2 * HALF) - 1), {1'b0, eu});
  assign bucket = 7'(64 - SUB_HALF_MAG - 1) - {1'b0, eu} - hdrh_pkg::clz64(cv | bmask);
  assign shamt = bucket + {1'b0, eu};
  assign sub = cv >> shamt[5:0];
  assign idx_full = (64'(bucket) + 64'd1) * 64'(HALF) + sub - 64'(HALF);

  // Value reported for the bin at the walk address.
  logic [AW-1:0] wa;
  logic [63:0]   bsub, lowv;
  logic [6:0]    bsh;
  assign wa = addr_r[AW-1:0];
  always_comb begin
    if ((wa >> SUB_HALF_MAG) == '0) begin
      bsub = 64'(wa);
      bsh = {1'b0, eu};
    end else begin
      bsub = 64'(wa & AW'(HALF - 1)) + 64'(HALF);
      bsh = 7'(wa >> SUB_HALF_MAG) - 7'd1 + {1'b0, eu};
    end
    lowv = hdrh_pkg::shl64(bsub, bsh);
  end

  // Equivalent range of the found bin value, bucketed again as a plain value,
  // so a value cut off at 64 bits reports the range of what is left.
  logic [6:0]  eb, esh;
  logic [63:0] elow, ehigh;
  assign eb = 7'(64 - SUB_HALF_MAG - 1) - {1'b0, eu} - hdrh_pkg::clz64(qv_r | bmask);
  assign esh = eb + {1'b0, eu};
  assign elow = hdrh_pkg::shl64(qv_r >> esh[5:0], esh);
  assign ehigh = elow + hdrh_pkg::shl64(64'd1, esh) - 64'd1;

  hdrh_target u_tgt (
    .clk(clk), .rst_n(rst_n), .start(tgt_start), .pct(pct_r),
    .total(tot_r), .done(tgt_done), .target(tgt_val)
  );

  logic [32:0] csum;
  logic [63:0] run_add;
  assign csum = {1'b0, rd_q} + {1'b0, cnt_r};
  assign run_add = run_r + 64'(rd_q);

  always_comb begin
    st_nxt = st_r;
    addr_nxt = addr_r;
    idx_ok_nxt = idx_ok_r;
    clr_res_nxt = clr_res_r;
    cnt_nxt = cnt_r;
    pct_nxt = pct_r;
    tgt_nxt = tgt_r;
    run_nxt = run_r;
    qv_nxt = qv_r;
    tot_nxt = tot_r;
    clp_nxt = clp_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    rd_addr = addr_r[AW-1:0];
    wr_addr = addr_r[AW-1:0];
    wr_data = '0;
    wr_en = 1'b0;
    tgt_start = 1'b0;
    case (st_r)
      S_CLR: begin
        wr_en = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (AW+1)'(DEPTH - 1)) begin
          // A clear request owes a result item; the sweep after reset does not.
          st_nxt = clr_res_r ? S_OUT : S_IDLE;
          clr_res_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          qv_nxt = '0;
          case (req.req_type)
            hdrh_pkg::REQ_RECORD: begin
              idx_ok_nxt = idx_full < 64'(DEPTH);
              addr_nxt = (AW+1)'(idx_full[AW-1:0]);
              rd_addr = idx_full[AW-1:0];
              cnt_nxt = req.count;
              tot_nxt = hdrh_pkg::sat_add64(tot_r, 64'(req.count));
              if (req.value > highest) begin
                clp_nxt = hdrh_pkg::sat_add64(clp_r, 64'(req.count));
              end
              if (tot_r == 64'd0 || cv < lo_r) lo_nxt = cv;
              if (tot_r == 64'd0 || cv > hi_r) hi_nxt = cv;
              st_nxt = S_RMW;
            end
            hdrh_pkg::REQ_QUERY: begin
              pct_nxt = req.pct;
              st_nxt = (tot_r == 64'd0) ? S_OUT : S_TGT;
              tgt_start = (tot_r != 64'd0);
            end
            hdrh_pkg::REQ_CLEAR: begin
              tot_nxt = '0;
              clp_nxt = '0;
              lo_nxt = '0;
              hi_nxt = '0;
              addr_nxt = '0;
              clr_res_nxt = 1'b1;
              st_nxt = S_CLR;
            end
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_RMW: begin
        wr_en = idx_ok_r;
        wr_data = csum[32] ? '1 : csum[31:0];
        st_nxt = S_OUT;
      end
      S_TGT: begin
        addr_nxt = '0;
        run_nxt = '0;
        rd_addr = '0;
        if (tgt_done) begin
          tgt_nxt = tgt_val;
          st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // rd_q holds the counter at addr_r.
        rd_addr = AW'(addr_r + 1'b1);
        run_nxt = run_add;
        addr_nxt = addr_r + 1'b1;
        if (run_add >= tgt_r) begin
          qv_nxt = lowv;
          st_nxt = S_EQV;
        end else if (addr_r == (AW+1)'(DEPTH - 1)) begin
          qv_nxt = '0;
          st_nxt = S_OUT;
        end
      end
      S_EQV: begin
        qv_nxt = (pct_r == 14'd0) ? elow : ehigh;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Counter store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      addr_r <= '0;
      clr_res_r <= 1'b0;
      tot_r <= '0;
      clp_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      st_r <= st_nxt;
      addr_r <= addr_nxt;
      clr_res_r <= clr_res_nxt;
      tot_r <= tot_nxt;
      clp_r <= clp_nxt;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    idx_ok_r <= idx_ok_nxt;
    cnt_r <= cnt_nxt;
    pct_r <= pct_nxt;
    tgt_r <= tgt_nxt;
    run_r <= run_nxt;
    qv_r <= qv_nxt;
  end

  assign req_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res_query = qv_r;
  assign res_stats.total = tot_r;
  assign res_stats.clamped = clp_r;
  assign res_stats.min_v = (tot_r != 64'd0) ? lo_r : 64'd0;
  assign res_stats.max_v = (tot_r != 64'd0) ? hi_r : 64'd0;

  // A result never shows while a request is taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_ready && res_valid)) else $error("ready and result overlap");
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_query))
    else $error("result changed under stall");
  // The memory is written only in clear, record write-back.
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (st_r == S_CLR || st_r == S_RMW)) else $error("stray write");
  // Record write-back goes straight to the result.
  a_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RMW |=> st_r == S_OUT) else $error("rmw sequence broken");

endmodule

// File: bench/hdr_checker.sv
// Checker for the HDR latency histogram: watches both streams and the register port.
`timescale 1ns / 1ps

module hdr_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [319:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           errors,
  output int           pending
);
  localparam int SHM       = hdrh_pkg::SUB_HALF_MAG_DEF;
  localparam int HALF      = 1 << SHM;
  localparam int BIN_DEPTH = (hdrh_pkg::BUCKETS_DEF + 1) << SHM;

  typedef struct packed {
    logic [63:0] max_v;
    logic [63:0] min_v;
    logic [63:0] clamped;
    logic [63:0] total;
    logic [63:0] qval;
  } summary_t;

  // Histogram image kept alongside the block.
  logic [31:0] bin_img [BIN_DEPTH];
  logic [63:0] tot_cnt, clamp_cnt, lo_mark, hi_mark;
  logic [5:0]  unit_mag;
  logic [63:0] top_value;
  summary_t    expected_summaries[$];
  int          item_no;

  assign pending = expected_summaries.size();

  function automatic logic [63:0] shift_up(input logic [63:0] v, input int s);
    return (s >= 64) ? 64'd0 : (v << s);
  endfunction

  function automatic int lead0(input logic [63:0] v);
    int n;
    n = 0;
    while (n < 64 && !v[63 - n]) n++;
    return n;
  endfunction

  // Resolution unit, saturated so sub-buckets still fit in 64 bits.
  function automatic int unit_eff();
    return (unit_mag > 6'(63 - SHM)) ? 63 - SHM : int'(unit_mag);
  endfunction

  function automatic int bucket_of(input logic [63:0] v);
    int          u;
    logic [63:0] mask;
    u = unit_eff();
    mask = (64'(2 * HALF) - 64'd1) << u;
    return (64 - u - (SHM + 1)) - lead0(v | mask);
  endfunction

  function automatic logic [63:0] low_equiv(input logic [63:0] v);
    int s;
    s = bucket_of(v) + unit_eff();
    return shift_up(v >> s, s);
  endfunction

  function automatic logic [63:0] high_equiv(input logic [63:0] v);
    int s;
    s = bucket_of(v) + unit_eff();
    return low_equiv(v) + shift_up(64'd1, s) - 64'd1;
  endfunction

  function automatic logic [63:0] bin_value(input int idx);
    int          hi;
    int          b;
    logic [63:0] sub;
    hi = idx >> SHM;
    sub = 64'(idx & (HALF - 1)) + 64'(HALF);
    if (hi == 0) begin
      sub = sub - 64'(HALF);
      b = 0;
    end else begin
      b = hi - 1;
    end
    return shift_up(sub, b + unit_eff());
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Record a value count times into the image.
  function automatic void record_value(input logic [63:0] v, input logic [31:0] cnt);
    logic        clamp;
    logic        empty;
    int          b;
    logic [63:0] idx;
    logic [32:0] c;
    clamp = (v > top_value);
    empty = (tot_cnt == 0);
    if (clamp) v = top_value;
    b = bucket_of(v);
    idx = 64'((b + 1) << SHM) + (v >> (b + unit_eff())) - 64'(HALF);
    if (idx < 64'(BIN_DEPTH)) begin
      c = {1'b0, bin_img[idx]} + {1'b0, cnt};
      bin_img[idx] = c[32] ? 32'hFFFF_FFFF : c[31:0];
    end
    tot_cnt = add_sat(tot_cnt, 64'(cnt));
    if (clamp) clamp_cnt = add_sat(clamp_cnt, 64'(cnt));
    if (empty || v < lo_mark) lo_mark = v;
    if (empty || v > hi_mark) hi_mark = v;
  endfunction

  // Percentile walk with exact rounding of the target count.
  function automatic logic [63:0] percentile_value(input logic [13:0] pct);
    logic [63:0] p, q, r, target, run;
    if (tot_cnt == 0) return 64'd0;
    p = (pct > 14'd10000) ? 64'd10000 : 64'(pct);
    q = tot_cnt / 64'd10000;
    r = tot_cnt % 64'd10000;
    target = p * q + (p * r + 64'd5000) / 64'd10000;
    if (target == 0) target = 64'd1;
    run = 0;
    for (int i = 0; i < BIN_DEPTH; i++) begin
      run = run + 64'(bin_img[i]);
      if (run >= target)
        return (p == 0) ? low_equiv(bin_value(i)) : high_equiv(bin_value(i));
    end
    return 64'd0;
  endfunction

  function automatic void clear_image();
    foreach (bin_img[i]) bin_img[i] = '0;
    tot_cnt = 0;
    clamp_cnt = 0;
    lo_mark = 0;
    hi_mark = 0;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    $display("mismatch on result item %0d: %s got %h expected %h", item_no, what, got, exp_v);
    errors++;
  endtask

  always @(posedge clk) begin
    summary_t exp_s;
    summary_t got_s;
    if (!rst_n) begin
      errors = 0;
      item_no = 0;
      clear_image();
      unit_mag <= 6'd0;
      top_value <= hdrh_pkg::HT_RESET;
      expected_summaries.delete();
    end else begin
      // Result items are compared before a new item is predicted.
      if (out_tvalid && out_tready) begin
        got_s = out_tdata;
        if (expected_summaries.size() == 0) begin
          report("result with no request outstanding", got_s.qval, 64'd0);
        end else begin
          exp_s = expected_summaries.pop_front();
          if (got_s.qval != exp_s.qval) report("query_value", got_s.qval, exp_s.qval);
          if (got_s.total != exp_s.total) report("total_samples", got_s.total, exp_s.total);
          if (got_s.clamped != exp_s.clamped)
            report("clamped_samples", got_s.clamped, exp_s.clamped);
          if (got_s.min_v != exp_s.min_v) report("min_seen", got_s.min_v, exp_s.min_v);
          if (got_s.max_v != exp_s.max_v) report("max_seen", got_s.max_v, exp_s.max_v);
        end
        item_no++;
      end
      if (in_tvalid && in_tready) begin
        exp_s.qval = 64'd0;
        case (in_tuser)
          hdrh_pkg::REQ_RECORD: record_value(in_tdata[63:0], in_tdata[95:64]);
          hdrh_pkg::REQ_QUERY:  exp_s.qval = percentile_value(in_tdata[109:96]);
          hdrh_pkg::REQ_CLEAR:  clear_image();
          default: ;
        endcase
        exp_s.total = tot_cnt;
        exp_s.clamped = clamp_cnt;
        exp_s.min_v = (tot_cnt != 0) ? lo_mark : 64'd0;
        exp_s.max_v = (tot_cnt != 0) ? hi_mark : 64'd0;
        expected_summaries.push_back(exp_s);
      end
      // Register writes take effect for the items that follow.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == hdrh_pkg::ADDR_UNIT) unit_mag <= cfg_pwdata[5:0];
        else if (cfg_paddr == hdrh_pkg::ADDR_HT) top_value <= cfg_pwdata;
      end
    end
  end

endmodule

// File: bench/tb_top.sv
// Testbench top for the HDR latency histogram: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
  localparam int CYCLE_LIMIT = 8000000;
  localparam logic [1:0] REQ_UNDEF = 2'd3;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  logic [111:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [319:0] out_tdata;
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata, cfg_prdata;
  logic         cfg_pready;
  int           errors, pending;
  int           cycles;
  int           burst_left;
  logic         hold_req;
  logic [63:0]  cur_top;

  hdr_latency_histogram u_top (.*);

  hdr_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .errors, .pending
  );

  // Clock and cycle limit.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: changing stall patterns, plus one long hold-off on request.
  initial begin
    logic hold_seen;
    int   mode;
    int   mode_left;
    out_tready = 1'b0;
    hold_seen = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_tready = 1'b0;
        repeat (600) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 1) == 0);
        default: out_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one item and hold it until accepted; gaps come between bursts.
  task automatic send_item(input logic [1:0] kind, input logic [63:0] v,
                           input logic [31:0] cnt, input logic [13:0] pct);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    burst_left--;
    in_tuser = kind;
    in_tdata = {2'b00, pct, cnt, v};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Values spread over all magnitudes, with the clamp boundary often hit.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return cur_top;
      1: return cur_top + 64'd1;
      2: return '1;
      3: return 64'd0;
      default: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic [13:0] pick_pct();
    case ($urandom_range(0, 7))
      0: return 14'd0;
      1: return 14'd10000;
      2: return 14'($urandom_range(10001, 16383));
      default: return 14'($urandom_range(0, 10000));
    endcase
  endfunction

  task automatic random_items(input int n);
    int  roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        send_item(hdrh_pkg::REQ_RECORD, pick_value(), pick_count(), 14'($urandom()));
      end else if (roll < 92) begin
        send_item(hdrh_pkg::REQ_QUERY, {$urandom(), $urandom()}, $urandom(), pick_pct());
      end else if (roll < 95) begin
        send_item(hdrh_pkg::REQ_CLEAR, {$urandom(), $urandom()}, $urandom(),
                  14'($urandom()));
      end else begin
        send_item(REQ_UNDEF, pick_value(), $urandom(), 14'($urandom()));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [5:0]  unit_set [6];
    logic [63:0] top_set [6];
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = hdrh_pkg::REQ_RECORD;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = hdrh_pkg::ADDR_UNIT;
    cfg_pwdata = '0;
    hold_req = 1'b0;
    burst_left = 0;
    cur_top = hdrh_pkg::HT_RESET;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed items under the reset configuration.
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd5000);
    send_item(hdrh_pkg::REQ_RECORD, 64'd77, 32'd0, 14'd0);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd10000);
    send_item(hdrh_pkg::REQ_RECORD, 64'd0, 32'd1, 14'd0);
    send_item(hdrh_pkg::REQ_RECORD, 64'd255, 32'd3, 14'd0);
    send_item(hdrh_pkg::REQ_RECORD, 64'd256, 32'd2, 14'd0);
    send_item(hdrh_pkg::REQ_RECORD, hdrh_pkg::HT_RESET, 32'd1, 14'd0);
    send_item(hdrh_pkg::REQ_RECORD, '1, 32'hFFFF_FFFF, 14'd0);
    send_item(hdrh_pkg::REQ_RECORD, '1, 32'hFFFF_FFFF, 14'd0);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd0);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd1);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd5000);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd10000);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'h3FFF);
    send_item(REQ_UNDEF, '1, '1, '1);
    send_item(hdrh_pkg::REQ_CLEAR, 64'd0, 32'd0, 14'd0);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd9999);
    drain();

    // A record whose bin lies past the counter store.
    write_reg(hdrh_pkg::ADDR_HT, '1);
    cur_top = '1;
    send_item(hdrh_pkg::REQ_RECORD, 64'h8000_0000_0000_0000, 32'd5, 14'd0);
    send_item(hdrh_pkg::REQ_RECORD, 64'd3, 32'd5, 14'd0);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd9000);
    // Large unit change while samples are held.
    drain();
    write_reg(hdrh_pkg::ADDR_UNIT, 64'd63);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd0);
    send_item(hdrh_pkg::REQ_QUERY, 64'd0, 32'd0, 14'd10000);
    drain();

    // Random phases across several register settings.
    unit_set = '{6'd0, 6'd40, 6'd63, 6'd3, 6'd0, 6'd12};
    top_set = '{hdrh_pkg::HT_RESET, '1, 64'd2, 64'd1000000, '1, {32'd0, 32'hFFFF_FFFF}};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(hdrh_pkg::ADDR_UNIT, {58'd0, unit_set[ph]});
      write_reg(hdrh_pkg::ADDR_HT, top_set[ph]);
      cur_top = top_set[ph];
      if (ph == 1) begin
        random_items(30);
        hold_req = ~hold_req;
        random_items(20);
        drain();
        random_items(60);
      end else begin
        random_items(110);
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
